// ===== rtl/core/kts_pkg.sv =====
// Shared types and constants for the keyframe track sampler core.
// No dependencies; imported by kts_ctrl, kts_dp and the top level.
package kts_pkg;

    localparam int MAX_KEYS_DEF  = 64;
    localparam int FRAC_BITS_DEF = 16;

    localparam int SLOT_W   = 6;
    localparam int COUNT_W  = 7;
    localparam int VAL_W    = 32;
    localparam int REGION_W = 2;
    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = 104;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [REGION_W-1:0] REGION_BEFORE = 2'd0;
    localparam logic [REGION_W-1:0] REGION_INSIDE = 2'd1;
    localparam logic [REGION_W-1:0] REGION_AFTER  = 2'd2;

    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    typedef struct packed {
        logic       load_wr;
        logic       start;
        logic       first_sel;
        logic       prev_load;
        logic       addr_next;
        logic       div_start;
        logic       last_sel;
        logic       advance;
        logic       mul_en;
        logic [1:0] mul_comp;
        logic       add_en;
        logic [1:0] add_comp;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic first_hit;
        logic seg_hit;
        logic last;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/core/keyframe_track_sampler_core.sv =====
// Top level of the keyframe track sampler: piecewise linear keyframe lookup.
// Instantiates kts_ctrl and kts_dp; uses kts_pkg.
//
// Load requests (tuser = 0) write one keyframe and give no result. A sample
// request (tuser = 1) scans the track from key 0, fetching and then checking
// each key in turn (one registered read port on the key memory); for an
// inside hit a restoring divider then finds the fraction one bit a cycle and
// one shared multiplier blends x, y and z in turn. The result then moves to
// the output register.
// The key memory holds whatever was last written; no clearing pass runs.
// A finished result waits in the output register while the next request
// is accepted.
module keyframe_track_sampler_core #(
    parameter int MAX_KEYS  = kts_pkg::MAX_KEYS_DEF,
    parameter int FRAC_BITS = kts_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // key_count write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [kts_pkg::COUNT_W-1:0]    i_cfg_data,
    // request: key_slot, key_time, key_x, key_y, key_z, sample_time, pad
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [kts_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // tuser: command
    input  logic                           i_s_tuser,
    // result: out_x, out_y, out_z, segment, region
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [kts_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import kts_pkg::*;

    t_cmd    w_cmd;
    t_status w_st;

    // config writes land at any time; the host only writes while idle
    assign o_cfg_ready = 1'b1;

    kts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_command  (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_st       (w_st),
        .o_cmd      (w_cmd)
    );

    kts_dp #(
        .MAX_KEYS  (MAX_KEYS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_st        (w_st),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

// ===== rtl/core/kts_ctrl.sv =====
// Controller state machine of the keyframe track sampler core.
// Depends on kts_pkg for the command and status structs.
module kts_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic             i_command,
    output logic             o_s_tready,
    input  kts_pkg::t_status i_st,
    output kts_pkg::t_cmd    o_cmd
);
    import kts_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_FETCH0, S_CHK0, S_FETCH, S_CHK, S_DIV,
        S_BL0, S_BL1, S_BL2, S_BL3, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   w_acc;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_acc      = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_command == CMD_SAMPLE) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_FETCH0;
                    end else begin
                        o_cmd.load_wr = 1'b1;
                    end
                end
            end
            S_FETCH0: n_state = S_CHK0;
            S_CHK0: begin
                o_cmd.prev_load = 1'b1;
                o_cmd.addr_next = 1'b1;
                if (i_st.first_hit) begin
                    o_cmd.first_sel = 1'b1;
                    n_state         = S_DONE;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: n_state = S_CHK;
            S_CHK: begin
                priority if (i_st.seg_hit) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else if (i_st.last) begin
                    o_cmd.last_sel = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.prev_load = 1'b1;
                    o_cmd.advance   = 1'b1;
                    n_state         = S_FETCH;
                end
            end
            S_DIV: if (i_st.div_done) n_state = S_BL0;
            S_BL0: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_comp = COMP_X;
                n_state        = S_BL1;
            end
            S_BL1: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_comp = COMP_Y;
                o_cmd.add_en   = 1'b1;
                o_cmd.add_comp = COMP_X;
                n_state        = S_BL2;
            end
            S_BL2: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_comp = COMP_Z;
                o_cmd.add_en   = 1'b1;
                o_cmd.add_comp = COMP_Y;
                n_state        = S_BL3;
            end
            S_BL3: begin
                o_cmd.add_en   = 1'b1;
                o_cmd.add_comp = COMP_Z;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (i_st.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // result only moves to the output register when it is free
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_st.out_free) else $error("output overwritten");
    // blend steps run through the state order, never skipping the divider
    a_div_before_blend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BL0) |-> $past(i_st.div_done)) else $error("blend early");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> !o_s_tready) else $error("accepted while busy");

endmodule

// ===== rtl/core/kts_dp.sv =====
// Datapath of the keyframe track sampler: key memory, scan registers,
// restoring divider, blend multiplier and output register. Uses kts_pkg.
module kts_dp #(
    parameter int MAX_KEYS  = kts_pkg::MAX_KEYS_DEF,
    parameter int FRAC_BITS = kts_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  kts_pkg::t_cmd                       i_cmd,
    output kts_pkg::t_status                    o_st,
    input  logic                                i_cfg_valid,
    input  logic [kts_pkg::COUNT_W-1:0]         i_cfg_data,
    input  logic [kts_pkg::IN_DATA_W-1:0]       i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [kts_pkg::OUT_DATA_W-1:0]      o_m_tdata
);
    import kts_pkg::*;

    localparam int AW  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CW  = $clog2(MAX_KEYS + 1);
    localparam int NW  = VAL_W + FRAC_BITS;
    localparam int DCW = $clog2(NW + 1);
    localparam int FW  = FRAC_BITS + 1;
    localparam int PW  = VAL_W + 1 + FW + 1;
    localparam int EW  = 4 * VAL_W;

    // input fields
    logic [SLOT_W-1:0] w_slot;
    logic [VAL_W-1:0]  w_ktime, w_sample;
    logic [VAL_W-1:0]  w_kv [3];
    assign w_slot   = i_s_tdata[5:0];
    assign w_ktime  = i_s_tdata[37:6];
    assign w_kv[0]  = i_s_tdata[69:38];
    assign w_kv[1]  = i_s_tdata[101:70];
    assign w_kv[2]  = i_s_tdata[133:102];
    assign w_sample = i_s_tdata[165:134];

    logic [COUNT_W-1:0] r_key_count;
    logic [CW-1:0]      w_n;
    logic [EW-1:0]      r_mem [MAX_KEYS];
    logic [EW-1:0]      r_rd;
    logic [AW-1:0]      r_addr, r_idx;
    logic [VAL_W-1:0]   r_t, r_prev_t;
    logic [VAL_W-1:0]   r_prev [3];
    logic [VAL_W-1:0]   r_cur  [3];
    logic [VAL_W-1:0]   r_res  [3];
    logic [VAL_W-1:0]   w_rd_t;
    logic [VAL_W-1:0]   w_rd_v [3];
    logic [SLOT_W-1:0]  r_seg;
    logic [REGION_W-1:0] r_region;

    logic [DCW-1:0]   r_div_cnt;
    logic [VAL_W:0]   r_rem;
    logic [VAL_W-1:0] r_den;
    logic [NW-1:0]    r_num, r_quo;
    logic             r_zero_span;
    logic [VAL_W:0]   w_rem2;
    logic             w_ge;
    logic [FW-1:0]    w_frac;

    logic signed [PW-1:0] r_prod;
    logic signed [VAL_W:0] w_diff;
    logic signed [PW-1:0] w_prod;
    logic signed [PW-1:0] w_sum;

    logic r_out_valid;
    logic [VAL_W-1:0]    r_out_v [3];
    logic [SLOT_W-1:0]   r_out_seg;
    logic [REGION_W-1:0] r_out_region;

    assign w_rd_t    = r_rd[31:0];
    assign w_rd_v[0] = r_rd[63:32];
    assign w_rd_v[1] = r_rd[95:64];
    assign w_rd_v[2] = r_rd[127:96];

    // clamp key_count to 1 .. MAX_KEYS
    always_comb begin
        if (r_key_count == '0) begin
            w_n = CW'(1);
        end else if (32'(r_key_count) > MAX_KEYS) begin
            w_n = CW'(MAX_KEYS);
        end else begin
            w_n = CW'(r_key_count);
        end
    end

    assign o_st.first_hit = (w_n == CW'(1)) || (r_t <= w_rd_t);
    assign o_st.seg_hit   = (r_prev_t <= r_t) && (r_t <= w_rd_t);
    assign o_st.last      = ((32'(r_idx) + 32'd2) == 32'(w_n));
    assign o_st.div_done  = (r_div_cnt == '0);
    assign o_st.out_free  = !r_out_valid || i_m_tready;

    assign w_rem2 = {r_rem[VAL_W-1:0], r_num[NW-1]};
    assign w_ge   = (w_rem2 >= {1'b0, r_den});
    assign w_frac = r_zero_span ? '0 : r_quo[FW-1:0];
    assign w_diff = $signed({r_cur[i_cmd.mul_comp][VAL_W-1], r_cur[i_cmd.mul_comp]})
                  - $signed({r_prev[i_cmd.mul_comp][VAL_W-1], r_prev[i_cmd.mul_comp]});
    assign w_prod = w_diff * $signed({1'b0, w_frac});
    assign w_sum  = PW'($signed(r_prev[i_cmd.add_comp])) + (r_prod >>> FRAC_BITS);

    // key memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && (32'(w_slot) < MAX_KEYS)) begin
            r_mem[AW'(w_slot)] <= {w_kv[2], w_kv[1], w_kv[0], w_ktime};
        end
        r_rd <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= COUNT_W'(1);
        end else if (i_cfg_valid) begin
            r_key_count <= i_cfg_data;
        end
    end

    // scan and blend payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_addr <= '0;
            r_idx  <= '0;
            r_t    <= w_sample;
        end
        if (i_cmd.addr_next || i_cmd.advance) r_addr <= r_addr + AW'(1);
        if (i_cmd.advance) r_idx <= r_idx + AW'(1);
        if (i_cmd.prev_load) begin
            r_prev_t <= w_rd_t;
            r_prev   <= w_rd_v;
        end
        if (i_cmd.first_sel) begin
            r_res    <= w_rd_v;
            r_seg    <= '0;
            r_region <= REGION_BEFORE;
        end
        if (i_cmd.last_sel) begin
            r_res    <= w_rd_v;
            r_seg    <= SLOT_W'(w_n - CW'(1));
            r_region <= REGION_AFTER;
        end
        if (i_cmd.div_start) begin
            r_cur       <= w_rd_v;
            r_seg       <= SLOT_W'(r_idx);
            r_region    <= REGION_INSIDE;
            r_num       <= {r_t - r_prev_t, {FRAC_BITS{1'b0}}};
            r_den       <= w_rd_t - r_prev_t;
            r_zero_span <= (w_rd_t == r_prev_t);
            r_rem       <= '0;
            r_quo       <= '0;
        end else if (r_div_cnt != '0) begin
            r_num <= r_num << 1;
            r_rem <= w_ge ? (w_rem2 - {1'b0, r_den}) : w_rem2;
            r_quo <= {r_quo[NW-2:0], w_ge};
        end
        if (i_cmd.mul_en) r_prod <= w_prod;
        if (i_cmd.add_en) r_res[i_cmd.add_comp] <= w_sum[VAL_W-1:0];
        if (i_cmd.out_load) begin
            r_out_v      <= r_res;
            r_out_seg    <= r_seg;
            r_out_region <= r_region;
        end
    end

    // control: divider count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.div_start) begin
                r_div_cnt <= DCW'(NW);
            end else if (r_div_cnt != '0) begin
                r_div_cnt <= r_div_cnt - DCW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_region, r_out_seg, r_out_v[2], r_out_v[1], r_out_v[0]};

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_div_cnt != '0) |=> (r_div_cnt == $past(r_div_cnt) - DCW'(1)))
        else $error("divider count slipped");
    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> (r_div_cnt == '0)) else $error("divider restarted");
    a_mul_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mul_en |-> (r_div_cnt == '0)) else $error("blend during divide");

endmodule

// ===== test/tb_keyframe_track_sampler_core.sv =====
// Testbench for keyframe_track_sampler_core: loads keyframe tracks, samples
// them at random times and checks every result against an in-bench predictor.
// Depends on kts_pkg and the core RTL only.
`timescale 1ns / 100ps

class track_scoreboard;
    logic [6:0]  key_count;
    logic [31:0] key_times [64];
    logic [31:0] key_x [64];
    logic [31:0] key_y [64];
    logic [31:0] key_z [64];
    logic [103:0] pending_results[$];
    int          errors;

    function new();
        key_count = 7'd1;
        errors = 0;
    endfunction

    // Compute a + floor((b - a) * f / 2^16).
    function logic [31:0] lerp_component(logic [31:0] a_bits, logic [31:0] b_bits,
                                         logic [63:0] frac);
        longint a;
        longint b;
        longint p;
        longint q;
        a = longint'($signed(a_bits));
        b = longint'($signed(b_bits));
        p = (b - a) * longint'(frac);
        q = p >>> 16;
        return a_bits + q[31:0];
    endfunction

    function void note_request(logic cmd, logic [167:0] data);
        logic [5:0]  slot;
        logic [31:0] t;
        logic [31:0] t0;
        logic [31:0] t1;
        logic [63:0] frac;
        int          n;
        logic [103:0] res;
        slot = data[5:0];
        if (cmd == kts_pkg::CMD_LOAD) begin
            key_times[slot] = data[37:6];
            key_x[slot] = data[69:38];
            key_y[slot] = data[101:70];
            key_z[slot] = data[133:102];
            return;
        end
        t = data[165:134];
        n = (key_count == 0) ? 1 : (key_count > 64 ? 64 : int'(key_count));
        if (n == 1 || t <= key_times[0]) begin
            res = {kts_pkg::REGION_BEFORE, 6'd0, key_z[0], key_y[0], key_x[0]};
            pending_results.push_back(res);
            return;
        end
        for (int i = 0; i + 1 < n; i++) begin
            t0 = key_times[i];
            t1 = key_times[i+1];
            if (t0 <= t && t <= t1) begin
                frac = (t1 == t0) ? 64'd0 : ({32'd0, t - t0} << 16) / {32'd0, t1 - t0};
                res = {kts_pkg::REGION_INSIDE, 6'(i),
                       lerp_component(key_z[i], key_z[i+1], frac),
                       lerp_component(key_y[i], key_y[i+1], frac),
                       lerp_component(key_x[i], key_x[i+1], frac)};
                pending_results.push_back(res);
                return;
            end
        end
        res = {kts_pkg::REGION_AFTER, 6'(n - 1), key_z[n-1], key_y[n-1], key_x[n-1]};
        pending_results.push_back(res);
    endfunction

    function void check_result(logic [103:0] got);
        logic [103:0] want;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        want = pending_results.pop_front();
        if (got[31:0] !== want[31:0])
            $display("%0t: out_x expected %h actual %h", $time, want[31:0], got[31:0]);
        if (got[63:32] !== want[63:32])
            $display("%0t: out_y expected %h actual %h", $time, want[63:32], got[63:32]);
        if (got[95:64] !== want[95:64])
            $display("%0t: out_z expected %h actual %h", $time, want[95:64], got[95:64]);
        if (got[101:96] !== want[101:96])
            $display("%0t: segment expected %0d actual %0d", $time, want[101:96],
                     got[101:96]);
        if (got[103:102] !== want[103:102])
            $display("%0t: region expected %0d actual %0d", $time, want[103:102],
                     got[103:102]);
        if (got !== want) errors++;
    endfunction
endclass

module tb_keyframe_track_sampler_core;
    import kts_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [COUNT_W-1:0]    cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    track_scoreboard sb;
    bit  written [64];   // slots loaded so far; never sample an unwritten one
    int  track_len;      // current key_count, clamped to 1 .. 64, as a plain number
    int  hold_cycles;    // receiver hold-off requested by the stimulus
    bit  in_burst;

    keyframe_track_sampler_core dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    always begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (in_burst || r < 55) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'd0;
            default: return $urandom();
        endcase
    endfunction

    // Offer one request and hold it until accepted; score it at acceptance.
    // Valid stays high after acceptance; drop it before a gap or any wait.
    task automatic send_request(logic cmd, logic [5:0] slot, logic [31:0] kt,
                                logic [31:0] kx, logic [31:0] ky, logic [31:0] kz,
                                logic [31:0] st);
        logic [IN_DATA_W-1:0] d;
        int g;
        d = {2'b00, st, kz, ky, kx, kt, slot};
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= d;
        do @(posedge clk); while (!s_tready);
        sb.note_request(cmd, d);
        if (cmd == CMD_LOAD) written[slot] = 1'b1;
    endtask

    task automatic send_load(int slot, logic [31:0] kt);
        send_request(CMD_LOAD, 6'(slot), kt, rand_word(), rand_word(), rand_word(),
                     $urandom());
    endtask

    task automatic send_sample(logic [31:0] st);
        send_request(CMD_SAMPLE, 6'($urandom()), $urandom(), $urandom(), $urandom(),
                     $urandom(), st);
    endtask

    // Drain outstanding results, let a load-only tail settle, then write key_count.
    task automatic write_key_count(logic [6:0] v);
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.key_count = v;
        track_len = (v == 0) ? 1 : (v > 64 ? 64 : int'(v));
    endtask

    // Load slots 0..n-1 with sorted times; sometimes repeat or shuffle times.
    task automatic load_track(int n, bit messy);
        logic [31:0] t;
        t = $urandom_range(0, 255) << 12;
        for (int i = 0; i < n; i++) begin
            if (messy && $urandom_range(0, 3) == 0) t = $urandom();
            else if ($urandom_range(0, 5) != 0) t = t + $urandom_range(1, 1 << 18);
            send_load(i, t);
        end
    endtask

    function automatic logic [31:0] pick_time();
        int k;
        k = $urandom_range(0, track_len - 1);
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return sb.key_times[k];
            3: return $urandom();
            default: return sb.key_times[k] + $urandom_range(0, 1 << 17);
        endcase
    endfunction

    // Receiver: random stalls plus a long hold-off when asked.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else if (in_burst) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) < 70);
            end
            if (m_tvalid && m_tready && rst_n) sb.check_result(m_tdata);
        end
    end

    initial begin
        #60_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int n;
        int phases [8];
        sb = new();
        hold_cycles = 0;
        in_burst = 0;
        track_len = 1;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: single key, extremes of values and times, zero-length segment.
        send_request(CMD_LOAD, 6'd0, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'd0, 32'hFFFF_FFFF);
        send_sample(32'd0);
        send_sample(32'hFFFF_FFFF);
        send_request(CMD_LOAD, 6'd1, 32'h0002_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'hFFFF_FFFF, 32'd0);
        send_request(CMD_LOAD, 6'd2, 32'h0002_0000, 32'd5, 32'hFFFF_FFFB, 32'd1, 32'd0);
        send_request(CMD_LOAD, 6'd3, 32'h0001_0000, 32'd7, 32'd8, 32'd9, 32'd0);
        send_request(CMD_LOAD, 6'd63, 32'hFFFF_FFFF, 32'd1, 32'd2, 32'd3, 32'd0);
        write_key_count(7'd3);
        send_sample(32'h0001_0000);
        send_sample(32'h0001_8000);
        send_sample(32'h0002_0000);
        send_sample(32'h0003_0000);
        write_key_count(7'd0);
        send_sample(32'h0001_8000);
        write_key_count(7'd4);
        send_sample(32'h0003_0000);   // unsorted times: falls past the scan
        send_sample(32'h0001_FFFF);
        for (int i = 4; i < 63; i++) send_load(i, 32'hFFFF_FFFF - 32'(63 - i));
        write_key_count(7'd127);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'hFFFF_FFFE);
        write_key_count(7'd64);
        send_sample(32'h0000_8000);

        // Long hold-off on the receiver while samples keep coming.
        hold_cycles = 3000;
        for (int i = 0; i < 12; i++) send_sample(pick_time());

        // Random phases: mostly short tracks, a few full ones.
        phases = '{2, 3, 5, 8, 1, 64, 16, 2};
        for (int p = 0; p < 24; p++) begin
            n = (p % 6 == 5) ? 64 : phases[$urandom_range(0, 7)];
            load_track(n, $urandom_range(0, 3) == 0);
            write_key_count((p % 7 == 3) ? 7'd0 : 7'(n));
            in_burst = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < 60; i++) begin
                if ($urandom_range(0, 9) == 0)
                    send_load($urandom_range(0, track_len - 1), pick_time());
                else
                    send_sample(pick_time());
            end
            in_burst = 0;
        end

        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
